/* hw/rtl/c8x_pkg.sv */
// Shared types and constants for the CHIP-8 execute block.
package c8x_pkg;

  localparam int MEM_BYTES_DEF = 4096;
  localparam int SCREEN_W = 64;
  localparam int SCREEN_H = 32;
  localparam int ROW_AW = 5;

  localparam logic [1:0] KIND_EXEC = 2'd0;
  localparam logic [1:0] KIND_MEMWR = 2'd1;
  localparam logic [1:0] KIND_ROWRD = 2'd2;

  localparam logic [3:0] OP_SYS = 4'h0;
  localparam logic [3:0] OP_JUMP = 4'h1;
  localparam logic [3:0] OP_LOAD = 4'h6;
  localparam logic [3:0] OP_ADD = 4'h7;
  localparam logic [3:0] OP_SETI = 4'hA;
  localparam logic [3:0] OP_DRAW = 4'hD;
  localparam logic [15:0] OPC_CLS = 16'h00E0;
  localparam logic [3:0] VF_IDX = 4'hF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DREAD,
    ST_DWRITE,
    ST_ROWRD,
    ST_OUT
  } c8x_state_t;

endpackage

/* hw/rtl/c8x_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
module c8x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/chip8_instruction_execute.sv */
// Top level of the CHIP-8 execute block: sequencer, registers and memories.
// Usage:
//   One item enters on the in_ channel (in_valid, in_stall) and gives one
//   result beat on the out_ channel (out_valid, out_stall). Items are
//   processed one at a time; in_stall is high while an item is in work or
//   its result is held.
//   From the accepting edge, register ops and memory writes go straight to
//   the result beat; a row read first captures the display row; 00E0 first
//   walks all 32 display rows; DXYN first takes, for each sprite row, the
//   memory read then the display row read-modify-write. 00E0 holds the
//   block longest of all items. The display RAM port and the sprite memory
//   port set this sequencing.
//   After reset the block runs a pass that clears the display RAM
//   and accepts no item meanwhile; V registers, I and pc reset to zero.
//   Main memory is not initialized.
//   When the receiver stalls, the result beat holds and no new item is taken.
module chip8_instruction_execute #(
  parameter int MEM_BYTES = c8x_pkg::MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_opcode,
  input  logic [11:0] in_mem_address,
  input  logic [7:0]  in_mem_byte,
  input  logic [4:0]  in_row_select,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_pc_value,
  output logic [11:0] out_index_value,
  output logic [7:0]  out_flag_value,
  output logic [63:0] out_display_row,
  output logic        out_unknown_op
);

  localparam int MAW = $clog2(MEM_BYTES);

  c8x_pkg::c8x_state_t state_r, state_nxt;

  logic [7:0]  vreg_r [16];
  logic [11:0] pc_r, idx_r;
  logic [4:0]  row_r;
  logic [3:0]  cnt_r;
  logic [3:0]  n_r;
  logic [5:0]  sx_r;
  logic        hit_r;
  logic [15:0] op_r;
  logic [63:0] orow_r;
  logic        ounk_r;
  logic [4:0]  sy_r;
  logic        init_r;

  // Memory ports.
  logic           mem_we;
  logic [MAW-1:0] mem_raddr;
  logic [7:0]     mem_rdata;
  logic           fb_we;
  logic [4:0]     fb_waddr, fb_raddr;
  logic [63:0]    fb_wdata, fb_rdata;

  c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .waddr(in_mem_address[MAW-1:0]),
    .wdata(in_mem_byte), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  c8x_ram #(.WIDTH(64), .DEPTH(c8x_pkg::SCREEN_H)) u_fb (
    .clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
    .raddr(fb_raddr), .rdata(fb_rdata)
  );

  logic accept;
  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != c8x_pkg::ST_IDLE);

  // Memory writes happen right at the accepting edge; out-of-range ignored.
  assign mem_we = accept && (in_kind == c8x_pkg::KIND_MEMWR) &&
                  ({1'b0, in_mem_address} < 13'(MEM_BYTES));
  assign mem_raddr = MAW'(idx_r + 12'(cnt_r));

  // Sprite row geometry for the current draw step.
  logic [5:0]   ycur;
  logic [127:0] wide;
  logic [63:0]  mask;
  assign ycur = {1'b0, sy_r} + {2'b0, cnt_r};
  assign wide = {mem_rdata, 120'b0} >> sx_r;
  assign mask = wide[127:64];

  always_comb begin
    fb_raddr = (state_r == c8x_pkg::ST_IDLE) ? in_row_select : ycur[4:0];
    fb_we = 1'b0;
    fb_waddr = row_r;
    fb_wdata = '0;
    if (state_r == c8x_pkg::ST_CLEAR) begin
      fb_we = 1'b1;
    end else if (state_r == c8x_pkg::ST_DWRITE) begin
      fb_we = !ycur[5];
      fb_waddr = ycur[4:0];
      fb_wdata = fb_rdata ^ mask;
    end
  end

  logic [3:0] op_hi, op_x, op_y;
  assign op_hi = in_opcode[15:12];
  assign op_x = in_opcode[11:8];
  assign op_y = in_opcode[7:4];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      c8x_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = c8x_pkg::ST_OUT;
          if (in_kind == c8x_pkg::KIND_ROWRD) begin
            state_nxt = c8x_pkg::ST_ROWRD;
          end else if (in_kind == c8x_pkg::KIND_EXEC) begin
            if (in_opcode == c8x_pkg::OPC_CLS) begin
              state_nxt = c8x_pkg::ST_CLEAR;
            end else if (op_hi == c8x_pkg::OP_DRAW && in_opcode[3:0] != 4'd0) begin
              state_nxt = c8x_pkg::ST_DREAD;
            end
          end
        end
      end
      c8x_pkg::ST_CLEAR: begin
        // The pass after reset has no item and so no result beat.
        if (row_r == 5'd31) begin
          state_nxt = init_r ? c8x_pkg::ST_IDLE : c8x_pkg::ST_OUT;
        end
      end
      c8x_pkg::ST_DREAD: state_nxt = c8x_pkg::ST_DWRITE;
      c8x_pkg::ST_DWRITE: begin
        state_nxt = (cnt_r + 4'd1 == n_r) ? c8x_pkg::ST_OUT : c8x_pkg::ST_DREAD;
      end
      c8x_pkg::ST_ROWRD: state_nxt = c8x_pkg::ST_OUT;
      c8x_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_nxt = c8x_pkg::ST_IDLE;
        end
      end
      default: state_nxt = c8x_pkg::ST_IDLE;
    endcase
  end

  // Control state; reset also starts the display clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= c8x_pkg::ST_CLEAR;
      init_r <= 1'b1;
      row_r <= '0;
      pc_r <= '0;
      idx_r <= '0;
      for (int i = 0; i < 16; i++) vreg_r[i] <= '0;
      hit_r <= 1'b0;
      ounk_r <= 1'b0;
      orow_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == c8x_pkg::ST_CLEAR) begin
        row_r <= row_r + 5'd1;
        if (row_r == 5'd31) init_r <= 1'b0;
      end
      if (state_r == c8x_pkg::ST_DWRITE) begin
        cnt_r <= cnt_r + 4'd1;
        if (!ycur[5] && |(fb_rdata & mask)) hit_r <= 1'b1;
        if (cnt_r + 4'd1 == n_r) vreg_r[c8x_pkg::VF_IDX] <= {7'd0, hit_r ||
          (!ycur[5] && |(fb_rdata & mask))};
      end
      if (state_r == c8x_pkg::ST_ROWRD) begin
        orow_r <= fb_rdata;
      end
      if (accept) begin
        orow_r <= '0;
        ounk_r <= 1'b0;
        row_r <= '0;
        cnt_r <= '0;
        hit_r <= 1'b0;
        if (in_kind == c8x_pkg::KIND_EXEC) begin
          case (op_hi)
            c8x_pkg::OP_SYS: ounk_r <= (in_opcode != c8x_pkg::OPC_CLS);
            c8x_pkg::OP_JUMP: pc_r <= in_opcode[11:0];
            c8x_pkg::OP_LOAD: vreg_r[op_x] <= in_opcode[7:0];
            c8x_pkg::OP_ADD: vreg_r[op_x] <= vreg_r[op_x] + in_opcode[7:0];
            c8x_pkg::OP_SETI: idx_r <= in_opcode[11:0];
            c8x_pkg::OP_DRAW: vreg_r[c8x_pkg::VF_IDX] <= '0;
            default: ounk_r <= 1'b1;
          endcase
        end
      end
    end
  end

  // Draw operands captured at accept (before VF is cleared).
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_opcode;
      n_r <= in_opcode[3:0];
      sx_r <= vreg_r[op_x][5:0];
      sy_r <= vreg_r[op_y][4:0];
    end
  end

  assign out_valid = (state_r == c8x_pkg::ST_OUT);
  assign out_pc_value = pc_r;
  assign out_index_value = idx_r;
  assign out_flag_value = vreg_r[c8x_pkg::VF_IDX];
  assign out_display_row = orow_r;
  assign out_unknown_op = ounk_r && (op_r != c8x_pkg::OPC_CLS);

endmodule

/* hw/rtl/c8x_checker.sv */
// Port-level checker for the CHIP-8 execute block, bound to the top level.
module c8x_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] out_pc_value,
  input logic [63:0] out_display_row,
  input logic        out_unknown_op
);

  // A result beat held under stall keeps its pc value and display row.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pc_value) &&
    $stable(out_display_row)) else $error("result beat changed under stall");

  // No item is taken while a result is pending.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while result pending");

  // An accepted item never yields a result in the same cycle.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid || $past(out_valid) == 1'b0)
    else $error("result beat too early");

  // Unknown flag and display row are never both set.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_unknown_op |-> out_display_row == 64'd0)
    else $error("unknown opcode carried display data");

endmodule

bind chip8_instruction_execute c8x_checker u_c8x_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_pc_value(out_pc_value),
  .out_display_row(out_display_row), .out_unknown_op(out_unknown_op)
);
